/* rtl/core/lru_block_cache_manager_core_macros.svh */
// ----------------------------------------------------------------------------
// LBCM assertion macros
// Shared concurrent assertion forms for the cache manager checkers.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_MANAGER_CORE_MACROS_SVH
`define LRU_BLOCK_CACHE_MANAGER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LBCM_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbcm: same-cycle check failed");

// next-cycle implication
`define LBCM_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbcm: next-cycle check failed");

`endif

/* rtl/core/lbcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBCM package
// Sizes, beat types and address helper for the LRU block cache manager.
// ----------------------------------------------------------------------------
package lbcm_pkg;

  localparam int MAX_SLOTS  = 128;
  localparam int NUM_LEVELS = 10;

  localparam int LVL_W   = 4;
  localparam int BLK_W   = 20;
  localparam int CAP_W   = 8;
  localparam int OSLOT_W = 7;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int LVL_IW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int MEM_DEPTH = NUM_LEVELS * MAX_SLOTS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [OSLOT_W-1:0] slot;
    logic               evict_valid;
    logic [BLK_W-1:0]   evicted_block;
  } res_t;

  // flat address of (level, slot) in the per-level directory memories
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [LVL_W-1:0]  lv,
                                                 input logic [SLOT_W-1:0] sl);
    logic [MEM_AW-1:0] base;
    base = MEM_AW'(lv) * MEM_AW'(MAX_SLOTS);
    return base + MEM_AW'(sl);
  endfunction

endpackage

/* rtl/core/lru_block_cache_manager_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache manager core
// Per-level LRU directory: hit lookup, slot allocation and LRU eviction.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_i and raise start_i; the beat is taken on a
//    clock edge with start_i high and busy_o low. busy_o stays high until the
//    result has been shown.
//  - Result channel: res_o is valid for exactly one cycle with res_valid_o.
//    The receiver cannot stall; it must take the beat in that cycle.
//  - Config channel: cfg_data_i (cache_capacity) is written on an edge with
//    cfg_valid_i and cfg_ready_o high; cfg_ready_o is high while idle.
//    A capacity of zero acts as one, above MAX_SLOTS acts as MAX_SLOTS.
//  - Sequence: a request runs a tag scan over the level's slots; a miss
//    that finds a free slot then allocates it, while a hit or an eviction
//    goes on to a pass over the recency list that shifts it. An eviction is
//    the worst case. Both passes go through the one read port of each
//    directory memory.
//  - A level out of range changes nothing and returns an all-zero result
//    in the cycle right after acceptance.
//  - Reset clears all entry counts to zero and capacity to 100; tag and
//    recency memories are not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module lru_block_cache_manager_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request
  input  logic                         start_i,
  output logic                         busy_o,
  input  lbcm_pkg::req_t               req_i,
  // result
  output logic                         res_valid_o,
  output lbcm_pkg::res_t               res_o,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lbcm_pkg::CAP_W-1:0]   cfg_data_i
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TSCAN  = 3'd1;  // scan tags of used slots
  localparam logic [2:0] ST_DECIDE = 3'd2;  // allocate or start eviction
  localparam logic [2:0] ST_EV_TAG = 3'd3;  // LRU slot known, read its tag
  localparam logic [2:0] ST_EV_RD  = 3'd4;  // capture victim, rewrite tag
  localparam logic [2:0] ST_OSCAN  = 3'd5;  // move slot to MRU end
  localparam logic [2:0] ST_DONE   = 3'd6;  // result beat

  localparam int SW = lbcm_pkg::SLOT_W;
  localparam int CW = lbcm_pkg::CNT_W;
  localparam int AW = lbcm_pkg::MEM_AW;

  // ---------------------------------------------------------------------------
  // Directory memories: one write and one registered read port each
  // ---------------------------------------------------------------------------
  logic [lbcm_pkg::BLK_W-1:0] tag_mem [lbcm_pkg::MEM_DEPTH];
  logic [SW-1:0]              ord_mem [lbcm_pkg::MEM_DEPTH];

  logic                       tag_we, ord_we;
  logic [AW-1:0]              tag_waddr, tag_raddr, ord_waddr, ord_raddr;
  logic [lbcm_pkg::BLK_W-1:0] tag_wdata, tag_rd_q;
  logic [SW-1:0]              ord_wdata, ord_rd_q;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rd_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [2:0]                 state_q, state_d;
  logic [lbcm_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]              cnt_q [lbcm_pkg::NUM_LEVELS];
  logic                       cnt_inc;

  logic [lbcm_pkg::LVL_W-1:0] lv_q, lv_d;
  logic [lbcm_pkg::BLK_W-1:0] blk_q, blk_d;
  logic [CW-1:0]              n_q, n_d;        // entry count of the level
  logic [CW-1:0]              idx_q, idx_d;    // scan position
  logic                       pend_q, pend_d;  // read in flight
  logic [SW-1:0]              pidx_q, pidx_d;  // position of data in flight
  logic [SW-1:0]              slot_q, slot_d;
  logic                       found_q, found_d;
  logic                       hit_q, hit_d;
  logic                       ev_q, ev_d;
  logic [lbcm_pkg::BLK_W-1:0] evblk_q, evblk_d;
  lbcm_pkg::res_t             res_q, res_d;

  logic [CW-1:0]              cap_eff;
  logic                       issue;
  logic [CW-1:0]              nm1;
  logic [SW-1:0]              pidx_m1;

  // capacity clamp to [1, MAX_SLOTS]
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > lbcm_pkg::MAX_SLOTS) begin
      cap_eff = CW'(lbcm_pkg::MAX_SLOTS);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign issue   = (idx_q < n_q);
  assign nm1     = n_q - CW'(1);
  assign pidx_m1 = pidx_q - SW'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    lv_d    = lv_q;
    blk_d   = blk_q;
    n_d     = n_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    slot_d  = slot_q;
    found_d = found_q;
    hit_d   = hit_q;
    ev_d    = ev_q;
    evblk_d = evblk_q;
    res_d   = res_q;
    cnt_inc = 1'b0;

    tag_we    = 1'b0;
    tag_waddr = lbcm_pkg::mem_addr(lv_q, slot_q);
    tag_wdata = blk_q;
    tag_raddr = lbcm_pkg::mem_addr(lv_q, idx_q[SW-1:0]);
    ord_we    = 1'b0;
    ord_waddr = lbcm_pkg::mem_addr(lv_q, pidx_m1);
    ord_wdata = ord_rd_q;
    ord_raddr = lbcm_pkg::mem_addr(lv_q, idx_q[SW-1:0]);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          lv_d    = req_i.level;
          blk_d   = req_i.block_number;
          idx_d   = '0;
          hit_d   = 1'b0;
          found_d = 1'b0;
          ev_d    = 1'b0;
          evblk_d = '0;
          if (32'(req_i.level) >= lbcm_pkg::NUM_LEVELS) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            n_d     = cnt_q[req_i.level[lbcm_pkg::LVL_IW-1:0]];
            state_d = ST_TSCAN;
          end
        end
      end

      ST_TSCAN: begin
        // one tag read per cycle, compared in the next cycle
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        pend_d = issue;
        pidx_d = idx_q[SW-1:0];
        if (pend_q && (tag_rd_q == blk_q)) begin
          hit_d   = 1'b1;
          slot_d  = pidx_q;
          idx_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          state_d = ST_OSCAN;
        end else if (!issue && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (n_q < cap_eff) begin
          // free slot: slots are handed out in order, so it is slot n
          tag_we    = 1'b1;
          tag_waddr = lbcm_pkg::mem_addr(lv_q, n_q[SW-1:0]);
          ord_we    = 1'b1;
          ord_waddr = lbcm_pkg::mem_addr(lv_q, n_q[SW-1:0]);
          ord_wdata = n_q[SW-1:0];
          cnt_inc   = 1'b1;
          res_d     = '{hit: 1'b0, slot: lbcm_pkg::OSLOT_W'(n_q[SW-1:0]),
                        evict_valid: 1'b0, evicted_block: '0};
          state_d   = ST_DONE;
        end else begin
          ord_raddr = lbcm_pkg::mem_addr(lv_q, '0);
          state_d   = ST_EV_TAG;
        end
      end

      ST_EV_TAG: begin
        slot_d    = ord_rd_q;
        tag_raddr = lbcm_pkg::mem_addr(lv_q, ord_rd_q);
        state_d   = ST_EV_RD;
      end

      ST_EV_RD: begin
        ev_d    = 1'b1;
        evblk_d = tag_rd_q;
        tag_we  = 1'b1;
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ST_OSCAN;
      end

      ST_OSCAN: begin
        // walk LRU..MRU; after the slot is seen, pull each entry down one
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        pend_d = issue;
        pidx_d = idx_q[SW-1:0];
        if (pend_q) begin
          if (found_q) begin
            ord_we = 1'b1;
          end else if (ord_rd_q == slot_q) begin
            found_d = 1'b1;
          end
        end
        if (!issue && !pend_q) begin
          ord_we    = 1'b1;
          ord_waddr = lbcm_pkg::mem_addr(lv_q, nm1[SW-1:0]);
          ord_wdata = slot_q;
          res_d     = '{hit: hit_q, slot: lbcm_pkg::OSLOT_W'(slot_q),
                        evict_valid: ev_q, evicted_block: evblk_q};
          state_d   = ST_DONE;
        end
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= lbcm_pkg::CAP_RESET;
      pend_q  <= 1'b0;
      for (int l = 0; l < lbcm_pkg::NUM_LEVELS; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (cnt_inc) begin
        cnt_q[lv_q[lbcm_pkg::LVL_IW-1:0]] <= n_q + CW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lv_q    <= lv_d;
    blk_q   <= blk_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    ev_q    <= ev_d;
    evblk_q <= evblk_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/core/lbcm_sva.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBCM port checker
// Port-level checks on the cache manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_block_cache_manager_core_macros.svh"

module lbcm_sva (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           res_valid_i,
  input lbcm_pkg::res_t res_i
);

  // accepted request keeps the block busy next cycle
  `LBCM_AST_NEXT(a_start_busy, start_i && !busy_i, busy_i)
  // result beat only shows while a request is in progress
  `LBCM_AST_NOW(a_res_in_busy, res_valid_i, busy_i)
  // one beat per request
  `LBCM_AST_NEXT(a_single_beat, res_valid_i, !res_valid_i)
  // victim field is zero without an eviction
  `LBCM_AST_NOW(a_evict_zero, res_valid_i && !res_i.evict_valid, res_i.evicted_block == '0)
  // a hit never evicts
  `LBCM_AST_NOW(a_hit_no_evict, res_valid_i && res_i.hit, !res_i.evict_valid)

endmodule

bind lru_block_cache_manager_core lbcm_sva u_lbcm_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_i      (busy_o),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
